// ===== rtl/dda_pkg.sv =====
package dda_pkg;

  localparam int COORD_BITS    = 12;
  localparam int COLOUR_BITS   = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic                         command;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;
    logic [COLOUR_BITS-1:0]       line_colour;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [COLOUR_BITS-1:0]       pixel_colour;
    logic                         last;
  } out_item_t;

  typedef struct packed {
    logic load_en;
    logic setup_en;
    logic div_en;
    logic fix_en;
    logic step_en;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic steps_nz;
  } dp_stat_t;

endpackage

// ===== rtl/dda_line_rasterizer_core.sv =====
// DDA line rasterizer.
// Input channel (in_valid/in_stall/in_data): a load transaction (command 0)
// takes both endpoints and a colour; a step transaction (command 1) advances
// the current line by one pixel.
// Output channel (out_valid/out_stall/out_data): one pixel per step while a
// line is active, last set on the end point. The start point is not plotted.
// A load gives no output. Then in_stall stays high through setup, divide
// and fix while the bit-serial divider forms the per-step increments (one
// quotient bit per cycle, both axes together); zero length stops at setup.
// A step's pixel appears in out_data the cycle after the transaction; steps
// are taken every cycle while the output register drains. A step with no
// line active is taken and gives nothing. A load drops any unfinished line.
// When out_stall holds a pending pixel, in_stall rises until it is taken.
// Reset (rst_n low, synchronous) leaves the block idle with no line active
// and no pixel pending.
module dda_line_rasterizer_core #(
  parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dda_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dda_pkg::out_item_t out_data
);

  dda_pkg::dp_cmd_t  cmd;
  dda_pkg::dp_stat_t stat;

  dda_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_command(in_data.command),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  dda_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .out_data(out_data),
    .cmd     (cmd),
    .stat    (stat)
  );

  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.command == dda_pkg::CMD_LOAD) |=> in_stall)
    else $error("load not followed by busy");

  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.step_en))
    else $error("output valid without a step");

  a_step_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_en |=> out_valid)
    else $error("active step gave no pixel");

  a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step_en |-> !(cmd.setup_en || cmd.div_en || cmd.fix_en))
    else $error("step during divide");

endmodule

// ===== rtl/dda_ctrl.sv =====
module dda_ctrl #(
  parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_command,
  output logic              in_stall,
  input  logic              out_stall,
  output logic              out_valid,
  output dda_pkg::dp_cmd_t  cmd,
  input  dda_pkg::dp_stat_t stat
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_FIX   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;

  always_comb begin
    in_stall     = (state_r != ST_IDLE) || (out_valid_r && out_stall);
    accept       = in_valid && !in_stall;
    cmd          = '0;
    cmd.load_en  = accept && (in_command == dda_pkg::CMD_LOAD);
    cmd.step_en  = accept && (in_command == dda_pkg::CMD_STEP) && stat.steps_nz;
    cmd.setup_en = (state_r == ST_SETUP);
    cmd.div_en   = (state_r == ST_DIV);
    cmd.fix_en   = (state_r == ST_FIX);
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load_en) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        cnt_nxt   = '0;
        state_nxt = stat.n_zero ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == CNT_LAST) state_nxt = ST_FIX;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_FIX: begin
        state_nxt = ST_IDLE;
      end
    endcase
    priority if (cmd.step_en) out_valid_nxt = 1'b1;
    else if (!out_stall)      out_valid_nxt = 1'b0;
    else                      out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/dda_dp.sv =====
module dda_dp #(
  parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dda_pkg::in_item_t  in_data,
  output dda_pkg::out_item_t out_data,
  input  dda_pkg::dp_cmd_t   cmd,
  output dda_pkg::dp_stat_t  stat
);

  localparam int C = dda_pkg::COORD_BITS;
  localparam int F = FRAC_BITS;
  localparam int P = C + F + 1;
  localparam int S = F + 2;
  localparam logic [P-1:0] HALF   = P'(1) << (F - 1);
  localparam logic [P-1:0] HALF_M = HALF - P'(1);

  logic signed [C:0]      dx_r, dy_r;
  logic [P-1:0]           pos_x_r, pos_y_r;
  logic [S-1:0]           step_x_r, step_y_r;
  logic [C-1:0]           steps_left_r;
  logic [C-1:0]           n_r;
  logic [C:0]             rem_x_r, rem_y_r;
  logic [F:0]             q_x_r, q_y_r;
  logic [dda_pkg::COLOUR_BITS-1:0] colour_r;
  dda_pkg::out_item_t     out_r;

  logic [C:0]   dx_nxt, dy_nxt, ax_full, ay_full;
  logic [C-1:0] ax, ay, n_comb;
  logic [C:0]   sub_x, sub_y, sel_x, sel_y;
  logic         ge_x, ge_y;
  logic [S-1:0] qx_ext, qy_ext;
  logic [P-1:0] pos_x_nxt, pos_y_nxt, rnd_x, rnd_y;

  always_comb begin
    dx_nxt  = {in_data.x_end[C-1], in_data.x_end} - {in_data.x_start[C-1], in_data.x_start};
    dy_nxt  = {in_data.y_end[C-1], in_data.y_end} - {in_data.y_start[C-1], in_data.y_start};
    ax_full = dx_r[C] ? -dx_r : dx_r;
    ay_full = dy_r[C] ? -dy_r : dy_r;
    ax      = ax_full[C-1:0];
    ay      = ay_full[C-1:0];
    n_comb  = (ax > ay) ? ax : ay;
    // one restoring-division step per cycle, x and y share the divisor
    sub_x   = rem_x_r - {1'b0, n_r};
    sub_y   = rem_y_r - {1'b0, n_r};
    ge_x    = rem_x_r >= {1'b0, n_r};
    ge_y    = rem_y_r >= {1'b0, n_r};
    sel_x   = ge_x ? sub_x : rem_x_r;
    sel_y   = ge_y ? sub_y : rem_y_r;
    qx_ext  = {1'b0, q_x_r};
    qy_ext  = {1'b0, q_y_r};
    pos_x_nxt = pos_x_r + {{(P-S){step_x_r[S-1]}}, step_x_r};
    pos_y_nxt = pos_y_r + {{(P-S){step_y_r[S-1]}}, step_y_r};
    // round half away from zero
    rnd_x   = pos_x_nxt + (pos_x_nxt[P-1] ? HALF_M : HALF);
    rnd_y   = pos_y_nxt + (pos_y_nxt[P-1] ? HALF_M : HALF);
    stat.n_zero   = (n_comb == '0);
    stat.steps_nz = (steps_left_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_left_r <= '0;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      step_x_r     <= '0;
      step_y_r     <= '0;
      colour_r     <= '0;
    end else begin
      if (cmd.load_en) begin
        steps_left_r <= '0;
        pos_x_r      <= {in_data.x_start[C-1], in_data.x_start, {F{1'b0}}};
        pos_y_r      <= {in_data.y_start[C-1], in_data.y_start, {F{1'b0}}};
        colour_r     <= in_data.line_colour;
      end else if (cmd.fix_en) begin
        steps_left_r <= n_r;
        step_x_r     <= dx_r[C] ? -qx_ext : qx_ext;
        step_y_r     <= dy_r[C] ? -qy_ext : qy_ext;
      end else if (cmd.step_en) begin
        steps_left_r <= steps_left_r - 1'b1;
        pos_x_r      <= pos_x_nxt;
        pos_y_r      <= pos_y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
    if (cmd.setup_en) begin
      n_r     <= n_comb;
      rem_x_r <= {1'b0, ax};
      rem_y_r <= {1'b0, ay};
      q_x_r   <= '0;
      q_y_r   <= '0;
    end else if (cmd.div_en) begin
      rem_x_r <= {sel_x[C-1:0], 1'b0};
      rem_y_r <= {sel_y[C-1:0], 1'b0};
      q_x_r   <= {q_x_r[F-1:0], ge_x};
      q_y_r   <= {q_y_r[F-1:0], ge_y};
    end
    if (cmd.step_en) begin
      out_r.pixel_x      <= rnd_x[F+C-1:F];
      out_r.pixel_y      <= rnd_y[F+C-1:F];
      out_r.pixel_colour <= colour_r;
      out_r.last         <= (steps_left_r == C'(1));
    end
  end

  assign out_data = out_r;

endmodule
